// ----- design/pwcd_pkg.sv -----
// ----------------------------------------------------------------------------
// pwcd_pkg
// Shared types, widths, constants and helpers for the position window
// convergence detector.
// ----------------------------------------------------------------------------
package pwcd_pkg;

  // Window geometry
  localparam int WINDOW_MAX = 16;
  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

  // Field widths
  localparam int POS_W      = 35;
  localparam int WLEN_W     = 5;
  localparam int THR_W      = 20;
  localparam int CFG_W      = 20;
  localparam int DEV_W      = 63;
  localparam int FILL_W     = 5;

  // Datapath widths
  localparam int SUM_W      = POS_W + PTR_W + 1;  // window sum, signed
  localparam int MEAN_W     = POS_W + 1;          // rounded mean, signed
  localparam int DIFF_W     = POS_W + 2;          // position minus mean, signed
  localparam int MUL_W      = 32;                 // squarer operand
  localparam int DIVC_W     = $clog2(SUM_W + 1);  // divider step counter

  // Reset values of the configuration registers
  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(10);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(100);

  // Largest magnitude whose square stays below 2^63
  localparam logic [DIFF_W-1:0] SQRT_SAT   = DIFF_W'(64'd3037000499);
  localparam logic [DEV_W-1:0]  DEV_SAT    = {DEV_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_WINDOW_LENGTH = 1'b0,
    CFG_THRESHOLD_MM  = 1'b1
  } cfg_idx_e;

  // Position types: one axis, and all three axes packed {z, y, x}
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [2:0][POS_W-1:0]   pos3_t;

  // Axis codes
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // Saturating add of two squared distances
  function automatic logic [DEV_W-1:0] sat_add(input logic [DEV_W-1:0] a,
                                               input logic [DEV_W-1:0] b);
    logic [DEV_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DEV_W] ? DEV_SAT : s[DEV_W-1:0];
  endfunction

endpackage

// ----- design/pwcd_if.sv -----
// ----------------------------------------------------------------------------
// pwcd_if
// Valid/ready channels of the detector: position input and result output.
// ----------------------------------------------------------------------------
interface pwcd_in_if;
  logic             valid;
  logic             ready;
  pwcd_pkg::pos_t   pos_x;
  pwcd_pkg::pos_t   pos_y;
  pwcd_pkg::pos_t   pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  output ready);
endinterface

interface pwcd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          converged;
  logic [pwcd_pkg::FILL_W-1:0]   window_fill;
  logic [pwcd_pkg::DEV_W-1:0]    max_dev_sq;

  modport source (output valid, output converged, output window_fill,
                  output max_dev_sq, input ready);
  modport sink   (input valid, input converged, input window_fill,
                  input max_dev_sq, output ready);
endinterface

// ----- design/position_window_convergence_detector_core.sv -----
// ----------------------------------------------------------------------------
// position_window_convergence_detector_core
// Sliding window of 3D positions; latches a converged flag once every held
// position lies strictly within the threshold distance of the window mean.
// ----------------------------------------------------------------------------
// Each accepted position is written into a 16-entry ring window until the
// flag is latched. While the window is still filling, or once the flag is
// latched, the result appears in the cycle after acceptance. With a full
// window the check sums the window entry by entry, runs three 40-step
// restoring divisions (one per axis, on a single shared divider) for the
// rounded mean, then reads each entry again while a single 32x32 squarer
// handles the x, y and z deviations in turn, and ends with one squaring of the
// threshold and a final compare. Input ready is low during the whole check.
// A finished result sits in an output register; input ready also stays low
// while it waits, and a check stalls at its end until the register is free.
module position_window_convergence_detector_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  pwcd_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [pwcd_pkg::CFG_W-1:0]    cfg_data_i,
  pwcd_in_if.sink                       in_if,
  pwcd_out_if.source                    out_if
);
  import pwcd_pkg::*;

  // Sequencer states
  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SUM_RD  = 9'b000000010,
    S_SUM_ACC = 9'b000000100,
    S_DIV     = 9'b000001000,
    S_DEV_RD  = 9'b000010000,
    S_DEV_MUL = 9'b000100000,
    S_DEV_ADD = 9'b001000000,
    S_THR     = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_e;

  // Control registers
  state_e              state_q, state_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [PTR_W-1:0]    wp_q, wp_d;
  logic                conv_q, conv_d;
  logic [WLEN_W-1:0]   wlen_q;
  logic [THR_W-1:0]    thr_q;
  logic                out_valid_q, out_valid_d;

  // Datapath registers
  pos3_t               mem_q [WINDOW_MAX];
  pos3_t               rd_q;
  logic [CNT_W-1:0]    k_q, k_d;
  axis_e               ax_q, ax_d;
  logic signed [SUM_W-1:0]  sum_q [3];
  logic signed [SUM_W-1:0]  sum_d [3];
  logic signed [MEAN_W-1:0] mean_q [3];
  logic signed [MEAN_W-1:0] mean_d [3];
  logic [SUM_W-1:0]    div_num_q, div_num_d;
  logic [CNT_W-1:0]    div_rem_q, div_rem_d;
  logic [DIVC_W-1:0]   div_cnt_q, div_cnt_d;
  logic                div_load_q, div_load_d;
  logic [DEV_W-1:0]    sq_q, sq_d;
  logic [DEV_W-1:0]    acc_q, acc_d;
  logic [DEV_W-1:0]    max_q, max_d;
  logic                out_conv_q, out_conv_d;
  logic [FILL_W-1:0]   out_fill_q, out_fill_d;
  logic [DEV_W-1:0]    out_dev_q, out_dev_d;

  // Combinational helpers
  logic                out_free;
  logic                accept;
  logic [CNT_W-1:0]    len_eff;
  logic [CNT_W-1:0]    fill_inc;
  logic [CNT_W-1:0]    fill_new;
  logic                k_last;
  logic                wr_en;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [SUM_W-1:0]    sum_mag;
  logic [CNT_W:0]      rem_trial;
  logic                q_bit;
  logic [SUM_W-1:0]    quot;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]   diff_mag;
  logic                sq_sat;
  logic [MUL_W-1:0]    mul_a;
  logic [2*MUL_W-1:0]  prod;
  logic [DEV_W-1:0]    acc_sum;

  // Handshake
  assign out_free    = !out_valid_q || out_if.ready;
  assign in_if.ready = (state_q == S_IDLE) && out_free;
  assign accept      = in_if.valid && in_if.ready;

  assign out_if.valid       = out_valid_q;
  assign out_if.converged   = out_conv_q;
  assign out_if.window_fill = out_fill_q;
  assign out_if.max_dev_sq  = out_dev_q;

  // Effective window length and next fill level
  always_comb begin
    if (wlen_q == '0) begin
      len_eff = CNT_W'(1);
    end else if (int'(wlen_q) > WINDOW_MAX) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = CNT_W'(wlen_q);
    end
    fill_inc = fill_q + CNT_W'(1);
    fill_new = (fill_inc < len_eff) ? fill_inc : len_eff;
  end

  // Walk from newest entry backwards
  assign k_last  = ((k_q + CNT_W'(1)) == fill_q);
  assign rd_addr = wp_q - PTR_W'(1) - k_q[PTR_W-1:0];

  // Shared divider step: one quotient bit per cycle
  assign sum_mag   = sum_q[ax_q][SUM_W-1] ? SUM_W'(-sum_q[ax_q]) : SUM_W'(sum_q[ax_q]);
  assign rem_trial = {div_rem_q, div_num_q[SUM_W-1]};
  assign q_bit     = (rem_trial >= {1'b0, fill_q});
  assign quot      = {div_num_q[SUM_W-2:0], q_bit};

  // Deviation of the selected axis and the shared squarer
  assign diff     = DIFF_W'($signed(rd_q[ax_q])) - DIFF_W'(mean_q[ax_q]);
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign sq_sat   = (diff_mag > SQRT_SAT);
  assign mul_a    = (state_q == S_THR) ? MUL_W'(thr_q) : diff_mag[MUL_W-1:0];
  assign prod     = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_a);
  assign acc_sum  = sat_add(acc_q, sq_q);

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    wp_d        = wp_q;
    conv_d      = conv_q;
    out_valid_d = out_valid_q;
    k_d         = k_q;
    ax_d        = ax_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    div_num_d   = div_num_q;
    div_rem_d   = div_rem_q;
    div_cnt_d   = div_cnt_q;
    div_load_d  = div_load_q;
    sq_d        = sq_q;
    acc_d       = acc_q;
    max_d       = max_q;
    out_conv_d  = out_conv_q;
    out_fill_d  = out_fill_q;
    out_dev_d   = out_dev_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (conv_q) begin
            out_valid_d = 1'b1;
            out_conv_d  = 1'b1;
            out_fill_d  = FILL_W'(fill_q);
            out_dev_d   = '0;
          end else begin
            wr_en  = 1'b1;
            wp_d   = wp_q + PTR_W'(1);
            fill_d = fill_new;
            if (fill_new == len_eff) begin
              k_d     = '0;
              sum_d   = '{default: '0};
              state_d = S_SUM_RD;
            end else begin
              out_valid_d = 1'b1;
              out_conv_d  = 1'b0;
              out_fill_d  = FILL_W'(fill_new);
              out_dev_d   = '0;
            end
          end
        end
      end

      // Sum pass
      S_SUM_RD: begin
        rd_en   = 1'b1;
        state_d = S_SUM_ACC;
      end

      S_SUM_ACC: begin
        for (int a = 0; a < 3; a++) begin
          sum_d[a] = sum_q[a] + SUM_W'($signed(rd_q[a]));
        end
        k_d = k_q + CNT_W'(1);
        if (k_last) begin
          ax_d       = AXIS_X;
          div_load_d = 1'b1;
          state_d    = S_DIV;
        end else begin
          state_d = S_SUM_RD;
        end
      end

      // Rounded mean per axis: (|sum| + n/2) / n, sign restored
      S_DIV: begin
        if (div_load_q) begin
          div_num_d  = sum_mag + SUM_W'(fill_q >> 1);
          div_rem_d  = '0;
          div_cnt_d  = '0;
          div_load_d = 1'b0;
        end else begin
          div_num_d = quot;
          div_rem_d = q_bit ? CNT_W'(rem_trial - {1'b0, fill_q}) : CNT_W'(rem_trial);
          div_cnt_d = div_cnt_q + DIVC_W'(1);
          if (div_cnt_q == DIVC_W'(SUM_W - 1)) begin
            mean_d[ax_q] = sum_q[ax_q][SUM_W-1] ? MEAN_W'(-quot) : MEAN_W'(quot);
            if (ax_q == AXIS_Z) begin
              k_d     = '0;
              max_d   = '0;
              state_d = S_DEV_RD;
            end else begin
              ax_d       = axis_e'(ax_q + 2'd1);
              div_load_d = 1'b1;
            end
          end
        end
      end

      // Deviation pass: one axis squared per step
      S_DEV_RD: begin
        rd_en   = 1'b1;
        ax_d    = AXIS_X;
        acc_d   = '0;
        state_d = S_DEV_MUL;
      end

      S_DEV_MUL: begin
        sq_d    = sq_sat ? DEV_SAT : prod[DEV_W-1:0];
        state_d = S_DEV_ADD;
      end

      S_DEV_ADD: begin
        acc_d = acc_sum;
        if (ax_q == AXIS_Z) begin
          if (acc_sum > max_q) begin
            max_d = acc_sum;
          end
          k_d = k_q + CNT_W'(1);
          state_d = k_last ? S_THR : S_DEV_RD;
        end else begin
          ax_d    = axis_e'(ax_q + 2'd1);
          state_d = S_DEV_MUL;
        end
      end

      // Threshold squared through the same squarer
      S_THR: begin
        sq_d    = prod[DEV_W-1:0];
        state_d = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          conv_d      = (max_q < sq_q);
          out_valid_d = 1'b1;
          out_conv_d  = (max_q < sq_q);
          out_fill_d  = FILL_W'(fill_q);
          out_dev_d   = max_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      wp_q        <= '0;
      conv_q      <= 1'b0;
      out_valid_q <= 1'b0;
      wlen_q      <= WLEN_RESET;
      thr_q       <= THR_RESET;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      wp_q        <= wp_d;
      conv_q      <= conv_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WINDOW_LENGTH: wlen_q <= cfg_data_i[WLEN_W-1:0];
          CFG_THRESHOLD_MM:  thr_q  <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    ax_q       <= ax_d;
    sum_q      <= sum_d;
    mean_q     <= mean_d;
    div_num_q  <= div_num_d;
    div_rem_q  <= div_rem_d;
    div_cnt_q  <= div_cnt_d;
    div_load_q <= div_load_d;
    sq_q       <= sq_d;
    acc_q      <= acc_d;
    max_q      <= max_d;
    out_conv_q <= out_conv_d;
    out_fill_q <= out_fill_d;
    out_dev_q  <= out_dev_d;
  end

  // Window memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wp_q] <= {in_if.pos_z, in_if.pos_y, in_if.pos_x};
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the position window convergence detector. A queue
// of positions feeds a valid/ready driver. Each accepted transaction runs
// through a behavioral model of the window, the rounded mean and the largest
// squared deviation, and the expected verdict is queued. A monitor compares
// every result transaction field by field against the oldest expectation.
// The run has a directed pass over the extremes, randomized segments under
// varying window length and threshold, and a final convergence with ignored
// positions after it.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pwcd_pkg::*;

  localparam int          RANDOM_ITEMS = 1450;
  localparam int          QUIET_LIMIT  = 4000;
  localparam int          SETTLE_TIME  = 300;
  localparam logic [63:0] DEV_CAP      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint      ROOT_CAP     = 64'sd3037000499;
  localparam pos_t        POS_HI       = {1'b0, {(POS_W-1){1'b1}}};
  localparam pos_t        POS_LO       = {1'b1, {(POS_W-1){1'b0}}};

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
  } position_t;

  typedef struct packed {
    logic              converged;
    logic [FILL_W-1:0] fill;
    logic [DEV_W-1:0]  dev;
  } verdict_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  cfg_idx_e           cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;

  pwcd_in_if  pos_ch ();
  pwcd_out_if res_ch ();

  position_window_convergence_detector_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (pos_ch.sink),
    .out_if     (res_ch.source)
  );

  position_t pending_positions[$];
  verdict_t  expected_verdicts[$];
  int        send_idle_pct;
  int        recv_idle_pct;
  int        mismatch_count;
  int        quiet_cycles;

  // Behavioral copy of the detector state and its registers
  pos_t hist_x [WINDOW_MAX];
  pos_t hist_y [WINDOW_MAX];
  pos_t hist_z [WINDOW_MAX];
  int   hist_fill;
  int   hist_wr;
  bit   locked;
  int   cur_len;
  int   cur_thr;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Squared deviation, capped at the 63-bit maximum
  function automatic logic [63:0] sq_capped(input longint d);
    longint a;
    a = (d < 0) ? -d : d;
    if (a > ROOT_CAP) return DEV_CAP;
    return a * a;
  endfunction

  function automatic logic [63:0] add_capped(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > DEV_CAP) ? DEV_CAP : s;
  endfunction

  // Sum over count, nearest integer, ties away from zero
  function automatic longint mean_rounded(input longint sum, input int n);
    longint mag;
    mag = (sum < 0) ? -sum : sum;
    mag = (mag + n / 2) / n;
    return (sum < 0) ? -mag : mag;
  endfunction

  // Advance the window by one position and work out the verdict it yields
  function automatic verdict_t assess_position(input pos_t px, input pos_t py, input pos_t pz);
    verdict_t    v;
    logic [63:0] worst;
    logic [63:0] d;
    logic [63:0] lim;
    longint      sx, sy, sz, mx, my, mz;
    int          eff, k, slot;
    worst = '0;
    if (!locked) begin
      eff = (cur_len == 0) ? 1 : ((cur_len > WINDOW_MAX) ? WINDOW_MAX : cur_len);
      hist_x[hist_wr] = px;
      hist_y[hist_wr] = py;
      hist_z[hist_wr] = pz;
      hist_wr   = (hist_wr + 1) % WINDOW_MAX;
      hist_fill = (hist_fill + 1 < eff) ? hist_fill + 1 : eff;
      if (hist_fill >= eff) begin
        sx = 0;
        sy = 0;
        sz = 0;
        for (k = 0; k < hist_fill; k++) begin
          slot = (hist_wr + WINDOW_MAX - 1 - k) % WINDOW_MAX;
          sx += longint'(hist_x[slot]);
          sy += longint'(hist_y[slot]);
          sz += longint'(hist_z[slot]);
        end
        mx = mean_rounded(sx, hist_fill);
        my = mean_rounded(sy, hist_fill);
        mz = mean_rounded(sz, hist_fill);
        for (k = 0; k < hist_fill; k++) begin
          slot = (hist_wr + WINDOW_MAX - 1 - k) % WINDOW_MAX;
          d = add_capped(add_capped(sq_capped(longint'(hist_x[slot]) - mx),
                                    sq_capped(longint'(hist_y[slot]) - my)),
                         sq_capped(longint'(hist_z[slot]) - mz));
          if (d > worst) worst = d;
        end
        lim = 64'(cur_thr) * 64'(cur_thr);
        if (worst < lim) locked = 1'b1;
      end
    end
    v.converged = locked;
    v.fill      = hist_fill[FILL_W-1:0];
    v.dev       = worst[DEV_W-1:0];
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Position driver: predicts on acceptance, then offers the next transaction
  always @(posedge clk_i) begin : position_driver
    position_t nxt;
    if (!rst_ni) begin
      pos_ch.valid <= 1'b0;
    end else begin
      if (pos_ch.valid && pos_ch.ready)
        expected_verdicts.insert(expected_verdicts.size(),
                                 assess_position(pos_ch.pos_x, pos_ch.pos_y,
                                                 pos_ch.pos_z));
      if (!pos_ch.valid || pos_ch.ready) begin
        if (pending_positions.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = pending_positions.pop_front();
          pos_ch.valid <= 1'b1;
          pos_ch.pos_x <= nxt.x;
          pos_ch.pos_y <= nxt.y;
          pos_ch.pos_z <= nxt.z;
        end else begin
          pos_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i) begin : verdict_monitor
    verdict_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result transaction: conv %0b fill %0d dev %0d",
                                  res_ch.converged, res_ch.window_fill, res_ch.max_dev_sq));
      end else begin
        want = expected_verdicts.pop_front();
        if (res_ch.converged !== want.converged)
          report_mismatch($sformatf("converged %0b, expected %0b",
                                    res_ch.converged, want.converged));
        if (res_ch.window_fill !== want.fill)
          report_mismatch($sformatf("window_fill %0d, expected %0d",
                                    res_ch.window_fill, want.fill));
        if (res_ch.max_dev_sq !== want.dev)
          report_mismatch($sformatf("max_dev_sq %0d, expected %0d",
                                    res_ch.max_dev_sq, want.dev));
      end
    end
    res_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (pos_ch.valid && pos_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic push_position(input pos_t x, input pos_t y, input pos_t z);
    position_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_positions.insert(pending_positions.size(), p);
  endtask

  // Wait until every queued position went in and every verdict came out
  task automatic drain();
    do @(negedge clk_i);
    while (pending_positions.size() != 0 || pos_ch.valid || expected_verdicts.size() != 0);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_WINDOW_LENGTH) cur_len = int'(val[WLEN_W-1:0]);
    else                          cur_thr = int'(val[THR_W-1:0]);
  endtask

  // Both registers, in random order, with the block idle
  task automatic set_config(input int len, input int thr);
    drain();
    if ($urandom_range(1, 0)) begin
      write_register(CFG_WINDOW_LENGTH, CFG_W'(len));
      write_register(CFG_THRESHOLD_MM, CFG_W'(thr));
    end else begin
      write_register(CFG_THRESHOLD_MM, CFG_W'(thr));
      write_register(CFG_WINDOW_LENGTH, CFG_W'(len));
    end
    @(negedge clk_i);
  endtask

  function automatic pos_t any_pos();
    return pos_t'({$urandom, $urandom});
  endfunction

  // Random point within +/- 2^scale of base, wrapping at the field width
  function automatic pos_t near_pos(input longint base, input int scale);
    longint r;
    r = $signed({$urandom, $urandom});
    r = r >>> (63 - scale);
    return pos_t'(base + r);
  endfunction

  // Stimulus
  initial begin : stimulus
    int     random_items, seg_len, len, thr, spread, k;
    longint bx, by, bz, gap;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_WINDOW_LENGTH;
    cfg_data_i     = '0;
    send_idle_pct  = 33;
    recv_idle_pct  = 46;
    hist_fill      = 0;
    hist_wr        = 0;
    locked         = 1'b0;
    cur_len        = 10;
    cur_thr        = 100;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();

    // Reset settings, window still filling: no check yet
    push_position(POS_HI, POS_LO, '0);
    push_position(POS_LO, POS_HI, '1);
    push_position('0, '1, POS_HI);
    push_position('1, '0, POS_LO);

    // Shorter window while filling; huge spread saturates the deviation
    set_config(3, 100);
    push_position(POS_HI, POS_HI, POS_HI);
    push_position(POS_LO, POS_LO, POS_LO);
    push_position(POS_HI, POS_LO, POS_HI);

    // Zero length acts as one; zero threshold never converges
    set_config(0, 0);
    push_position(POS_LO, POS_HI, '0);
    push_position(pos_t'(1), pos_t'(-1), pos_t'(2));

    // Oversized length saturates to the maximum window; widest threshold
    set_config(31, (1 << THR_W) - 1);
    for (k = 0; k < WINDOW_MAX; k++) begin
      if (k % 2 == 0) push_position(POS_HI - pos_t'(k), POS_LO + pos_t'(k), pos_t'(k));
      else            push_position(POS_LO + pos_t'(k), POS_HI - pos_t'(k), pos_t'(-k));
    end

    // Random segments, each under its own window length and threshold
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 46;
      end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 46;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case ($urandom_range(7, 0))
        0:       len = 0;
        1:       len = 1;
        2:       len = WINDOW_MAX;
        3:       len = 31;
        default: len = $urandom_range(31, 0);
      endcase
      case ($urandom_range(5, 0))
        0, 1:    thr = 0;
        2:       thr = (1 << THR_W) - 1;
        3:       thr = $urandom_range((1 << THR_W) - 1, 1);
        default: thr = $urandom_range((1 << $urandom_range(THR_W - 1, 0)), 1);
      endcase
      // a one-entry window passes any nonzero threshold at once
      if (len <= 1) thr = 0;
      set_config(len, thr);

      bx      = longint'(any_pos()) >>> 1;
      by      = longint'(any_pos()) >>> 1;
      bz      = longint'(any_pos()) >>> 1;
      spread  = $urandom_range(POS_W - 1, 0);
      gap     = 2 * longint'(thr) + 2 + longint'($urandom_range(4096, 0));
      seg_len = $urandom_range(70, 20);
      for (k = 0; k < seg_len; k++) begin
        if ($urandom_range(99, 0) < 15)
          push_position(any_pos(), any_pos(), any_pos());
        else if (thr == 0)
          push_position(near_pos(bx, spread), near_pos(by, spread), near_pos(bz, spread));
        else
          // x alternates across a gap wider than twice the threshold
          push_position(pos_t'(bx + ((k % 2 != 0) ? gap : 0)),
                        near_pos(by, spread), near_pos(bz, spread));
      end
      random_items += seg_len;
    end

    // Deviation equal to the threshold fails; then convergence latches
    // and later positions are ignored
    send_idle_pct = 33;
    recv_idle_pct = 46;
    set_config(2, 5);
    push_position('0, '0, '0);
    push_position(pos_t'(10), '0, '0);
    push_position(pos_t'(9), '0, '0);
    for (k = 0; k < 4; k++) push_position(any_pos(), any_pos(), any_pos());

    drain();
    repeat (SETTLE_TIME) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pwcd_pkg.sv
design/pwcd_if.sv
design/position_window_convergence_detector_core.sv
test/testbench.sv
